/* rtl/core/xtsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtsc_pkg
// Shared types and codes for the XML token structure checker: the token and
// event transactions, grammar phases and the controller/datapath interface.
// ----------------------------------------------------------------------------
package xtsc_pkg;

    localparam int DEFAULT_MAX_DEPTH = 16;
    localparam int OPEN_DEPTH_W      = 5;

    typedef enum logic [3:0] {
        TK_END      = 4'd0,
        TK_XMLDECL  = 4'd1,
        TK_DOCTYPE  = 4'd2,
        TK_COMMENT  = 4'd3,
        TK_STARTBRA = 4'd4,
        TK_ATTR     = 4'd5,
        TK_KET      = 4'd6,
        TK_EMPTYKET = 4'd7,
        TK_ENDBRA   = 4'd8,
        TK_TEXT     = 4'd9
    } tok_kind_t;

    typedef enum logic [2:0] {
        EV_START    = 3'd0,
        EV_ATTR     = 3'd1,
        EV_EMPTY    = 3'd2,
        EV_ENDTAG   = 3'd3,
        EV_COMMENT  = 3'd4,
        EV_TEXT     = 3'd5,
        EV_ERROR    = 3'd6,
        EV_FINISHED = 3'd7
    } evt_kind_t;

    typedef enum logic [2:0] {
        ER_EOF    = 3'd0,
        ER_START  = 3'd1,
        ER_KET    = 3'd2,
        ER_ENDTAG = 3'd3,
        ER_DEEP   = 3'd4
    } err_code_t;

    typedef enum logic [3:0] {
        PH_DECL    = 4'd0,
        PH_MISC1   = 4'd1,
        PH_MISC2   = 4'd2,
        PH_ROOT    = 4'd3,
        PH_TAG     = 4'd4,
        PH_CONTENT = 4'd5,
        PH_ENDKET  = 4'd6,
        PH_EPI     = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

    typedef enum logic [1:0] {
        DEPTH_HOLD = 2'd0,
        DEPTH_INC  = 2'd1,
        DEPTH_DEC  = 2'd2
    } depth_op_t;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [15:0] token_ref;
    } tok_t;

    typedef struct packed {
        logic [2:0]              event_kind;
        logic [2:0]              error_code;
        logic [15:0]             event_ref;
        logic [OPEN_DEPTH_W-1:0] open_depth;
        logic                    last_event;
    } evt_t;

    // controller -> datapath
    typedef struct packed {
        logic      use_held;
        logic      load_tok;
        depth_op_t depth_op;
        logic      ev_load;
        evt_kind_t ev_kind;
        err_code_t err_code;
        logic      ref_pass;
        logic      last;
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [3:0] kind;
        logic       depth_zero;
        logic       depth_le1;
        logic       depth_full;
        logic       out_free;
    } dp_stat_t;

endpackage

/* rtl/core/xtsc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtsc_dp
// Datapath: held token register, nesting depth counter and the event
// output register.
// ----------------------------------------------------------------------------
module xtsc_dp
    import xtsc_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  tok_t     tok,
    input  logic     evt_stall,
    output logic     evt_valid,
    output evt_t     evt,
    input  dp_cmd_t  cmd,
    output dp_stat_t stat
);

    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);

    tok_t               tok_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] depth_next;
    logic               evt_valid_reg;
    logic               evt_valid_next;
    evt_t               evt_reg;
    evt_t               evt_next;
    tok_t               cur_tok;

    assign cur_tok = cmd.use_held ? tok_reg : tok;

    always_comb
    begin
        unique case (cmd.depth_op)
            DEPTH_INC: depth_next = depth_reg + DEPTH_W'(1);
            DEPTH_DEC: depth_next = (depth_reg == '0) ? depth_reg
                                                      : depth_reg - DEPTH_W'(1);
            default:   depth_next = depth_reg;
        endcase
    end

    always_comb
    begin
        evt_next.event_kind = cmd.ev_kind;
        evt_next.error_code = (cmd.ev_kind == EV_ERROR) ? cmd.err_code : ER_EOF;
        evt_next.event_ref  = cmd.ref_pass ? cur_tok.token_ref : 16'd0;
        evt_next.open_depth = OPEN_DEPTH_W'(depth_next);
        evt_next.last_event = cmd.last;
    end

    always_comb
    begin
        if (cmd.ev_load)
            evt_valid_next = 1'b1;
        else if (!evt_stall)
            evt_valid_next = 1'b0;
        else
            evt_valid_next = evt_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_reg     <= '0;
            evt_valid_reg <= 1'b0;
        end
        else
        begin
            depth_reg     <= depth_next;
            evt_valid_reg <= evt_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_tok)
            tok_reg <= tok;
        if (cmd.ev_load)
            evt_reg <= evt_next;
    end

    assign evt_valid       = evt_valid_reg;
    assign evt             = evt_reg;
    assign stat.kind       = cur_tok.token_kind;
    assign stat.depth_zero = (depth_reg == '0);
    assign stat.depth_le1  = (depth_reg <= DEPTH_W'(1));
    assign stat.depth_full = (depth_reg >= DEPTH_W'(MAX_DEPTH));
    assign stat.out_free   = !evt_valid_reg || !evt_stall;

`ifndef SYNTHESIS
    // depth never passes the configured limit
    assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_DEPTH))
        else $error("nesting depth above limit");
`endif

endmodule

/* rtl/core/xtsc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xtsc_ctrl
// Controller: grammar phase state machine and token hold flag. Works one
// grammar step per cycle when output is free; drives the datapath commands.
// ----------------------------------------------------------------------------
module xtsc_ctrl
    import xtsc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     tok_valid,
    output logic     tok_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   hold_reg;
    logic   hold_next;
    logic   fire;

    assign fire      = (hold_reg || tok_valid) && stat.out_free;
    assign tok_stall = hold_reg || !stat.out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DECL;
            hold_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hold_reg  <= hold_next;
        end
    end

    always_comb
    begin
        phase_t    ph;
        phase_t    nph;
        logic [3:0] k;
        logic      taken;
        logic      emit;
        depth_op_t dop;
        evt_kind_t ek;
        err_code_t ec;
        logic      pass;
        phase_t    parent_dec;
        phase_t    parent_now;

        k          = stat.kind;
        ph         = phase_reg;
        nph        = phase_reg;
        taken      = 1'b1;
        emit       = 1'b0;
        dop        = DEPTH_HOLD;
        ek         = EV_ERROR;
        ec         = ER_EOF;
        pass       = 1'b0;
        parent_dec = stat.depth_le1 ? PH_EPI : PH_CONTENT;
        parent_now = stat.depth_zero ? PH_EPI : PH_CONTENT;

        // fold the prolog steps that pass a token on without an event
        if (ph == PH_DECL && k != TK_XMLDECL)
            ph = PH_MISC1;
        if (ph == PH_MISC1 && k != TK_COMMENT && k != TK_DOCTYPE)
            ph = PH_ROOT;
        if (ph == PH_MISC2 && k != TK_COMMENT)
            ph = PH_ROOT;

        unique case (ph)
            PH_DECL:
                nph = PH_MISC1;
            PH_MISC1:
            begin
                if (k == TK_COMMENT)
                begin
                    emit = 1'b1; ek = EV_COMMENT; pass = 1'b1; nph = PH_MISC1;
                end
                else
                    nph = PH_MISC2;
            end
            PH_MISC2:
            begin
                emit = 1'b1; ek = EV_COMMENT; pass = 1'b1; nph = PH_MISC2;
            end
            PH_ROOT:
            begin
                emit = 1'b1;
                if (k == TK_STARTBRA)
                begin
                    if (stat.depth_full)
                    begin
                        ec = ER_DEEP; nph = PH_DONE;
                    end
                    else
                    begin
                        dop = DEPTH_INC; ek = EV_START; pass = 1'b1; nph = PH_TAG;
                    end
                end
                else
                begin
                    ec = ER_START; nph = PH_EPI; taken = 1'b0;
                end
            end
            PH_TAG:
            begin
                priority if (k == TK_ATTR)
                begin
                    emit = 1'b1; ek = EV_ATTR; pass = 1'b1;
                end
                else if (k == TK_KET)
                    nph = PH_CONTENT;
                else if (k == TK_EMPTYKET)
                begin
                    emit = 1'b1; ek = EV_EMPTY; dop = DEPTH_DEC; nph = parent_dec;
                end
                else
                begin
                    emit = 1'b1; ec = ER_KET; dop = DEPTH_DEC; nph = parent_dec;
                    taken = 1'b0;
                end
            end
            PH_CONTENT:
            begin
                emit = 1'b1;
                priority if (k == TK_COMMENT)
                begin
                    ek = EV_COMMENT; pass = 1'b1;
                end
                else if (k == TK_TEXT)
                begin
                    ek = EV_TEXT; pass = 1'b1;
                end
                else if (k == TK_STARTBRA)
                begin
                    if (stat.depth_full)
                    begin
                        ec = ER_DEEP; nph = PH_DONE;
                    end
                    else
                    begin
                        dop = DEPTH_INC; ek = EV_START; pass = 1'b1; nph = PH_TAG;
                    end
                end
                else if (k == TK_ENDBRA)
                begin
                    ek = EV_ENDTAG; dop = DEPTH_DEC; nph = PH_ENDKET;
                end
                else
                begin
                    ec = ER_ENDTAG; dop = DEPTH_DEC; nph = parent_dec; taken = 1'b0;
                end
            end
            PH_ENDKET:
            begin
                nph = parent_now;
                if (k != TK_KET)
                begin
                    emit = 1'b1; ec = ER_KET; taken = 1'b0;
                end
            end
            PH_EPI:
            begin
                emit = 1'b1;
                priority if (k == TK_COMMENT)
                begin
                    ek = EV_COMMENT; pass = 1'b1;
                end
                else if (k == TK_END)
                begin
                    ek = EV_FINISHED; nph = PH_DONE;
                end
                else
                begin
                    ec = ER_EOF; nph = PH_DONE;
                end
            end
            PH_DONE:
                nph = PH_DONE;
            default:
                nph = PH_DONE;
        endcase

        cmd.use_held = hold_reg;
        cmd.load_tok = tok_valid && !hold_reg;
        cmd.depth_op = fire ? dop : DEPTH_HOLD;
        cmd.ev_load  = fire && emit;
        cmd.ev_kind  = ek;
        cmd.err_code = ec;
        cmd.ref_pass = pass;
        // a step that hands the token on is always followed by another event
        cmd.last     = taken;

        phase_next = fire ? nph : phase_reg;
        hold_next  = fire ? !taken : hold_reg;
    end

`ifndef SYNTHESIS
    // a token is only handed on to a level that always produces an event
    assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> (phase_reg == PH_EPI || phase_reg == PH_CONTENT))
        else $error("held token in unexpected phase");

    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && hold_reg) |-> cmd.ev_load)
        else $error("held token step produced no event");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TAG || phase_reg == PH_ENDKET) |-> !stat.depth_zero
        || phase_reg == PH_ENDKET)
        else $error("tag phase with no open element");

    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DONE) |=> (phase_reg == PH_DONE && !hold_reg))
        else $error("left finished phase");
`endif

endmodule

/* rtl/core/xml_token_structure_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xml_token_structure_checker
// Checks a stream of XML tokens against the document grammar and emits
// structure events (tags, attributes, comments, text, errors, finished).
// ----------------------------------------------------------------------------
// A token yielding no event or one event is taken once the output is free, so
// tokens stream at one per cycle while the event output is free. A token that
// yields n events (an error cascading through open elements) is taken alike,
// then stalls the token input while the controller works on the held token,
// one grammar step per cycle while output is free, one event per step.
// Events leave through a single output register; while it is stalled the
// token input is stalled too. After a finished or end-of-file event, or a
// too-deep error, further tokens are accepted and dropped until reset.
// Nesting is limited to MAX_DEPTH open elements.
module xml_token_structure_checker
    import xtsc_pkg::*;
#(
    parameter int MAX_DEPTH = DEFAULT_MAX_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic tok_valid,
    output logic tok_stall,
    input  tok_t tok,
    output logic evt_valid,
    input  logic evt_stall,
    output evt_t evt
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    xtsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    xtsc_dp #(
        .MAX_DEPTH (MAX_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok),
        .evt_stall (evt_stall),
        .evt_valid (evt_valid),
        .evt       (evt),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds XML token transactions into the structure checker and compares every
// event it emits, field by field, with a behavioural parser kept alongside.
// Reset comes once, so the run parses one document: a directed prolog and
// element walk, a long random stretch held inside the root element, an
// unknown token at full depth that cascades to the end of the parse, and
// finally tokens that must be dropped without any event.
// ----------------------------------------------------------------------------
module testbench;
    import xtsc_pkg::*;

    localparam int DEPTH_LIMIT  = DEFAULT_MAX_DEPTH;
    localparam int MAX_EVENTS   = DEPTH_LIMIT + 2;
    localparam int IDLE_PCT     = 38;
    localparam int RANDOM_ITEMS = 100;
    localparam int HOLD_CYCLES  = 250;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        phase_t     phase;
        logic [4:0] depth;
    } parse_state_t;

    logic clk;
    logic rst_n;
    logic tok_valid;
    logic tok_stall;
    tok_t tok;
    logic evt_valid;
    logic evt_stall;
    evt_t evt;

    parse_state_t doc;
    evt_t         token_events [0:MAX_EVENTS-1];
    int           token_event_count;
    evt_t         events_due [$];
    int           mismatches  = 0;
    logic         quiet       = 1'b0;
    logic         hold_toggle = 1'b0;

    xml_token_structure_checker dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok_valid (tok_valid),
        .tok_stall (tok_stall),
        .tok       (tok),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioural parser
    // ------------------------------------------------------------------
    function automatic void note_event(evt_kind_t kind, logic [15:0] handle,
                                       logic [4:0] depth);
        evt_t e;
        e            = '0;
        e.event_kind = kind;
        e.event_ref  = handle;
        e.open_depth = depth;
        token_events[token_event_count] = e;
        token_event_count++;
    endfunction

    function automatic void note_error(err_code_t code, logic [4:0] depth);
        note_event(EV_ERROR, '0, depth);
        token_events[token_event_count - 1].error_code = code;
    endfunction

    function automatic phase_t enclosing_phase(logic [4:0] depth);
        return (depth == 0) ? PH_EPI : PH_CONTENT;
    endfunction

    function automatic void open_element(inout parse_state_t st, input logic [15:0] handle);
        if (st.depth >= DEPTH_LIMIT)
        begin
            note_error(ER_DEEP, st.depth);
            st.phase = PH_DONE;
        end
        else
        begin
            st.depth = st.depth + 5'd1;
            note_event(EV_START, handle, st.depth);
            st.phase = PH_TAG;
        end
    endfunction

    // Fills token_events with the events one token causes and advances st.
    function automatic void parse_token(inout parse_state_t st, input tok_t t);
        logic taken;
        token_event_count = 0;
        taken             = 1'b0;
        while (!taken)
        begin
            taken = 1'b1;
            case (st.phase)
                PH_DECL:
                begin
                    // no declaration is fine: look at the token again as misc
                    st.phase = PH_MISC1;
                    taken    = (t.token_kind == TK_XMLDECL);
                end
                PH_MISC1:
                    if (t.token_kind == TK_COMMENT)
                        note_event(EV_COMMENT, t.token_ref, st.depth);
                    else if (t.token_kind == TK_DOCTYPE)
                        st.phase = PH_MISC2;
                    else
                    begin
                        st.phase = PH_ROOT;
                        taken    = 1'b0;
                    end
                PH_MISC2:
                    if (t.token_kind == TK_COMMENT)
                        note_event(EV_COMMENT, t.token_ref, st.depth);
                    else
                    begin
                        st.phase = PH_ROOT;
                        taken    = 1'b0;
                    end
                PH_ROOT:
                    if (t.token_kind == TK_STARTBRA)
                        open_element(st, t.token_ref);
                    else
                    begin
                        note_error(ER_START, st.depth);
                        st.phase = PH_EPI;
                        taken    = 1'b0;
                    end
                PH_TAG:
                    if (t.token_kind == TK_ATTR)
                        note_event(EV_ATTR, t.token_ref, st.depth);
                    else if (t.token_kind == TK_KET)
                        st.phase = PH_CONTENT;
                    else
                    begin
                        if (st.depth > 0)
                            st.depth = st.depth - 5'd1;
                        if (t.token_kind == TK_EMPTYKET)
                            note_event(EV_EMPTY, '0, st.depth);
                        else
                        begin
                            note_error(ER_KET, st.depth);
                            taken = 1'b0;
                        end
                        st.phase = enclosing_phase(st.depth);
                    end
                PH_CONTENT:
                    if (t.token_kind == TK_COMMENT)
                        note_event(EV_COMMENT, t.token_ref, st.depth);
                    else if (t.token_kind == TK_TEXT)
                        note_event(EV_TEXT, t.token_ref, st.depth);
                    else if (t.token_kind == TK_STARTBRA)
                        open_element(st, t.token_ref);
                    else
                    begin
                        if (st.depth > 0)
                            st.depth = st.depth - 5'd1;
                        if (t.token_kind == TK_ENDBRA)
                        begin
                            note_event(EV_ENDTAG, '0, st.depth);
                            st.phase = PH_ENDKET;
                        end
                        else
                        begin
                            // abandon this element and let its parent look again
                            note_error(ER_ENDTAG, st.depth);
                            st.phase = enclosing_phase(st.depth);
                            taken    = 1'b0;
                        end
                    end
                PH_ENDKET:
                begin
                    if (t.token_kind != TK_KET)
                    begin
                        note_error(ER_KET, st.depth);
                        taken = 1'b0;
                    end
                    st.phase = enclosing_phase(st.depth);
                end
                PH_EPI:
                    if (t.token_kind == TK_COMMENT)
                        note_event(EV_COMMENT, t.token_ref, st.depth);
                    else
                    begin
                        if (t.token_kind == TK_END)
                            note_event(EV_FINISHED, '0, st.depth);
                        else
                            note_error(ER_EOF, st.depth);
                        st.phase = PH_DONE;
                    end
                default:
                    st.phase = PH_DONE;
            endcase
        end
        if (token_event_count > 0)
            token_events[token_event_count - 1].last_event = 1'b1;
    endfunction

    function automatic tok_t make_tok(logic [3:0] kind, logic [15:0] handle);
        tok_t t;
        t.token_kind = kind;
        t.token_ref  = handle;
        return t;
    endfunction

    // Mostly well-formed content for the current phase, with some noise.
    function automatic tok_t pick_token(parse_state_t st);
        tok_t        t;
        int unsigned roll;
        roll        = $urandom_range(99);
        t.token_ref = 16'($urandom);
        if (roll < 12)
            t.token_kind = 4'($urandom_range(15));
        else if (st.phase == PH_TAG)
            t.token_kind = (roll < 55) ? TK_ATTR : (roll < 80) ? TK_KET : TK_EMPTYKET;
        else if (st.phase == PH_ENDKET)
            t.token_kind = TK_KET;
        else
            t.token_kind = (roll < 40) ? TK_TEXT : (roll < 52) ? TK_COMMENT :
                           (roll < 76) ? TK_STARTBRA : TK_ENDBRA;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Token side
    // ------------------------------------------------------------------
    task automatic send_token(input tok_t t);
        @(negedge clk);
        while (!quiet && $urandom_range(99) < IDLE_PCT)
        begin
            tok_valid <= 1'b0;
            @(negedge clk);
        end
        tok_valid <= 1'b1;
        tok       <= t;
        @(posedge clk);
        while (tok_stall)
            @(posedge clk);
        parse_token(doc, t);
        for (int i = 0; i < token_event_count; i++)
            events_due.push_back(token_events[i]);
    endtask

    // ------------------------------------------------------------------
    // Event side: stall at random, or hold off for a long stretch on request
    // ------------------------------------------------------------------
    initial
    begin
        logic hold_seen;
        hold_seen = 1'b0;
        evt_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                evt_stall <= 1'b1;
                repeat (HOLD_CYCLES)
                    @(negedge clk);
            end
            evt_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        evt_t want;
        if (evt_valid && !evt_stall)
        begin
            if (events_due.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, actual kind %0d code %0d ref %h",
                         $time, evt.event_kind, evt.error_code, evt.event_ref);
                mismatches++;
            end
            else
            begin
                want = events_due.pop_front();
                if (evt.event_kind !== want.event_kind)
                    report_field("event_kind", want.event_kind, evt.event_kind);
                if (evt.error_code !== want.error_code)
                    report_field("error_code", want.error_code, evt.error_code);
                if (evt.event_ref !== want.event_ref)
                    report_field("event_ref", want.event_ref, evt.event_ref);
                if (evt.open_depth !== want.open_depth)
                    report_field("open_depth", want.open_depth, evt.open_depth);
                if (evt.last_event !== want.last_event)
                    report_field("last_event", want.last_event, evt.last_event);
            end
        end
    end

    // End the run if no transaction moves on either side for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((tok_valid && !tok_stall) || (evt_valid && !evt_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("testbench: errors");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_prolog();
        send_token(make_tok(TK_XMLDECL, 16'hFFFF));
        send_token(make_tok(TK_COMMENT, 16'h0000));
        send_token(make_tok(TK_COMMENT, 16'hFFFF));
        send_token(make_tok(TK_DOCTYPE, 16'($urandom)));
        send_token(make_tok(TK_COMMENT, 16'($urandom)));
        send_token(make_tok(TK_STARTBRA, 16'hFFFF));
        send_token(make_tok(TK_ATTR, 16'h0000));
        send_token(make_tok(TK_ATTR, 16'hFFFF));
        send_token(make_tok(TK_KET, 16'($urandom)));
    endtask

    task automatic test_element_ops();
        send_token(make_tok(TK_TEXT, 16'h0000));
        send_token(make_tok(TK_COMMENT, 16'hFFFF));
        // empty element
        send_token(make_tok(TK_STARTBRA, 16'($urandom)));
        send_token(make_tok(TK_ATTR, 16'($urandom)));
        send_token(make_tok(TK_EMPTYKET, 16'($urandom)));
        // element with text and an end tag
        send_token(make_tok(TK_STARTBRA, 16'($urandom)));
        send_token(make_tok(TK_KET, 16'($urandom)));
        send_token(make_tok(TK_TEXT, 16'hFFFF));
        send_token(make_tok(TK_ENDBRA, 16'($urandom)));
        send_token(make_tok(TK_KET, 16'($urandom)));
        // start tag left without its ket: text falls to the root
        send_token(make_tok(TK_STARTBRA, 16'($urandom)));
        send_token(make_tok(TK_TEXT, 16'($urandom)));
        // end bra without its ket: comment falls to the root
        send_token(make_tok(TK_STARTBRA, 16'($urandom)));
        send_token(make_tok(TK_KET, 16'($urandom)));
        send_token(make_tok(TK_ENDBRA, 16'($urandom)));
        send_token(make_tok(TK_COMMENT, 16'($urandom)));
    endtask

    // Random content that never closes the root, so the parse stays alive.
    task automatic test_random_stream();
        tok_t         t;
        parse_state_t probe;
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            if (k == 0 || k == 60)
                quiet = 1'b1;
            if (k == 30 || k == 80)
                quiet = 1'b0;
            // long hold-off on the event side while tokens keep coming
            if (k == 60)
                hold_toggle = !hold_toggle;
            do
            begin
                t     = pick_token(doc);
                probe = doc;
                parse_token(probe, t);
            end
            while (probe.depth == 0 || probe.phase == PH_EPI || probe.phase == PH_DONE);
            send_token(t);
        end
    endtask

    task automatic test_full_depth_cascade();
        while (doc.phase != PH_CONTENT)
            send_token(make_tok(TK_KET, 16'($urandom)));
        quiet       = 1'b1;
        hold_toggle = !hold_toggle;
        while (doc.depth < DEPTH_LIMIT)
        begin
            send_token(make_tok(TK_STARTBRA, 16'($urandom)));
            send_token(make_tok(TK_ATTR, 16'($urandom)));
            send_token(make_tok(TK_KET, 16'($urandom)));
        end
        quiet = 1'b0;
        // an unknown kind closes every open element, then ends the document
        send_token(make_tok(4'($urandom_range(15, 10)), 16'($urandom)));
    endtask

    task automatic test_after_parse();
        send_token(make_tok(TK_END, 16'($urandom)));
        send_token(make_tok(TK_STARTBRA, 16'($urandom)));
        send_token(make_tok(4'hF, 16'hFFFF));
        for (int k = 0; k < 6; k++)
            send_token(make_tok(4'($urandom_range(15)), 16'($urandom)));
    endtask

    initial
    begin
        rst_n     = 1'b0;
        tok_valid = 1'b0;
        tok       = '0;
        doc.phase = PH_DECL;
        doc.depth = '0;
        repeat (12)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_prolog();
        test_element_ops();
        test_random_stream();
        test_full_depth_cascade();
        test_after_parse();

        @(negedge clk);
        tok_valid <= 1'b0;
        while (events_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

/* files.f */
rtl/core/xtsc_pkg.sv
rtl/core/xtsc_dp.sv
rtl/core/xtsc_ctrl.sv
rtl/core/xml_token_structure_checker.sv
dv/testbench.sv
